>>> rtl/core/pdi_pkg.sv
package pdi_pkg;

   localparam int FRAME_MAX  = 16;
   localparam int FRAME_BASE = 12;
   localparam int IDLE_BITS  = 4;
   localparam int LEFT_W     = $clog2(FRAME_MAX + 1);

   localparam logic ACTION_SEND   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_RX = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] tx_byte;
      logic       idle_prefix;
      logic       line_bit;
   } pdi_req_type;

   typedef struct packed {
      logic       kind;
      logic       tx_bit;
      logic [7:0] rx_byte;
      logic       last;
   } pdi_rsp_type;

   // Byte completed by the receiver on the current sample.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } pdi_rx_evt_type;

endpackage

>>> rtl/core/pdi_frame_codec.sv
// Send: 12 line bits, or 16 with the idle prefix, one per cycle unless rsp_ready stalls;
// first bit goes via the serializer, then the output register. Sample: one sample per
// accepted transaction; its byte result, if any, goes via the byte register, then the
// output register. A new transaction is taken in the cycle the last pending result
// moves to the output register, so the result channel sets throughput. Synchronous
// active-high reset empties serializer and output register; receiver hunts a start bit.
module pdi_frame_codec
   import pdi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pdi_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pdi_rsp_type rsp_payload
);

   logic                 advance;
   logic                 req_fire;
   logic                 sample_fire;
   pdi_rx_evt_type       rx_evt;
   logic                 parity;
   logic [FRAME_MAX-1:0] frame_bits;

   logic [LEFT_W-1:0]    left_ff, left_in;
   logic [FRAME_MAX-1:0] bits_ff, bits_in;
   logic                 kind_ff, kind_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 out_valid_ff, out_valid_in;
   pdi_rsp_type          out_ff, out_in;

   assign advance     = !out_valid_ff || rsp_ready;
   assign req_ready   = (left_ff == '0) || (left_ff == LEFT_W'(1) && advance);
   assign req_fire    = req_valid && req_ready;
   assign sample_fire = req_fire && req_payload.action == ACTION_SAMPLE;

   pdi_rx u_rx (
      .clock        (clock),
      .reset        (reset),
      .sample_valid (sample_fire),
      .sample_bit   (req_payload.line_bit),
      .rx_evt       (rx_evt)
   );

   assign parity = ^req_payload.tx_byte;

   // Line bits in send order from bit zero: optional idle ones, start, data, parity, stops.
   always_comb begin
      if (req_payload.idle_prefix) begin
         frame_bits = {2'b11, parity, req_payload.tx_byte, 1'b0, {IDLE_BITS{1'b1}}};
      end else begin
         frame_bits = {{IDLE_BITS{1'b1}}, 2'b11, parity, req_payload.tx_byte, 1'b0};
      end
   end

   always_comb begin
      left_in      = left_ff;
      bits_in      = bits_ff;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (advance) begin
         out_valid_in = (left_ff != '0);
         out_in.kind    = kind_ff;
         out_in.tx_bit  = (kind_ff == KIND_RX) ? 1'b1 : bits_ff[0];
         out_in.rx_byte = (kind_ff == KIND_RX) ? byte_ff : 8'd0;
         out_in.last    = (left_ff == LEFT_W'(1));
         if (left_ff != '0) begin
            left_in = left_ff - LEFT_W'(1);
            bits_in = {1'b1, bits_ff[FRAME_MAX-1:1]};
         end
      end

      if (req_fire) begin
         if (req_payload.action == ACTION_SEND) begin
            kind_in = KIND_TX;
            bits_in = frame_bits;
            byte_in = '0;
            left_in = req_payload.idle_prefix ? LEFT_W'(FRAME_MAX) : LEFT_W'(FRAME_BASE);
         end else begin
            kind_in = KIND_RX;
            byte_in = rx_evt.data;
            left_in = rx_evt.valid ? LEFT_W'(1) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      out_ff  <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_ready_drained: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> left_ff <= LEFT_W'(1))
      else $error("new transaction taken while a frame is still pending");

   a_send_load: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.action == ACTION_SEND
      |=> left_ff == LEFT_W'(FRAME_BASE) || left_ff == LEFT_W'(FRAME_MAX))
      else $error("send transaction loaded a wrong frame length");

   a_rx_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_RX |-> rsp_payload.last && rsp_payload.tx_bit)
      else $error("received byte result not marked last at idle level");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_ff <= LEFT_W'(FRAME_MAX))
      else $error("serializer count out of range");

endmodule

>>> rtl/core/pdi_rx.sv
module pdi_rx
   import pdi_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           sample_valid,
   input  logic           sample_bit,
   output pdi_rx_evt_type rx_evt
);

   localparam logic [1:0] PH_HUNT  = 2'd0;
   localparam logic [1:0] PH_DATA  = 2'd1;
   localparam logic [1:0] PH_SKIP  = 2'd2;
   localparam logic [1:0] PH_SPARE = 2'd3;

   localparam logic [3:0] DATA_BITS = 4'd8;
   localparam logic [3:0] SKIP_BITS = 4'd3;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] count_ff, count_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] count_inc;

   assign count_inc = count_ff + 4'd1;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      shift_in    = shift_ff;
      rx_evt      = '0;
      rx_evt.data = shift_ff;
      if (sample_valid) begin
         case (phase_ff)
            PH_DATA: begin
               shift_in = {sample_bit, shift_ff[7:1]};
               count_in = count_inc;
               if (count_inc >= DATA_BITS) begin
                  rx_evt.valid = 1'b1;
                  rx_evt.data  = shift_in;
                  phase_in     = PH_SKIP;
                  count_in     = '0;
               end
            end
            PH_SKIP: begin
               count_in = count_inc;
               if (count_inc >= SKIP_BITS) begin
                  phase_in = PH_HUNT;
                  count_in = '0;
               end
            end
            default: begin
               // The unused phase code behaves as hunting.
               phase_in = PH_HUNT;
               if (!sample_bit) begin
                  phase_in = PH_DATA;
                  count_in = '0;
                  shift_in = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         shift_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
      end
   end

   a_spare_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_SPARE || count_ff == '0)
      else $error("receiver left in unused phase with a bit count");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> count_ff < DATA_BITS)
      else $error("data bit count out of range");

   a_skip_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> count_ff < SKIP_BITS)
      else $error("skip bit count out of range");

   a_evt_phase: assert property (@(posedge clock) disable iff (reset)
      rx_evt.valid |=> phase_ff == PH_SKIP && count_ff == '0)
      else $error("byte event did not move receiver to skip");

endmodule
